// ===== rtl/core/cfr_pkg.sv =====
//------------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver.
//------------------------------------------------------------------------------
package cfr_pkg;

	localparam int MAX_BODY = 14;
	localparam int ADDR_W   = $clog2(MAX_BODY);
	localparam int LEN_W    = 4;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = 1;
	localparam int Q_CNT_W  = 2;

	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [7:0] MIN_LEN    = 8'h02;
	localparam logic [7:0] MAX_LEN    = 8'(MAX_BODY);

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_START = 3'd1;
	localparam logic [2:0] ST_BAD_LEN  = 3'd2;
	localparam logic [2:0] ST_SHORT    = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;

	typedef struct packed {
		logic [2:0]       status;
		logic [LEN_W-1:0] length;
	} cfr_cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} cfr_wr_t;

endpackage

// ===== rtl/core/checksummed_frame_receiver.sv =====
//------------------------------------------------------------------------------
// checksummed_frame_receiver
// Length-prefixed serial frame receiver with an 8-bit negated-sum checksum.
//------------------------------------------------------------------------------
// Each input word is a received byte or a timeout tick. Bytes of a frame body
// are held off while an earlier result is still queued or draining, because
// the body store holds a single frame. A good frame of L bytes leaves as L
// words, each passing a store read, then the output register, and an error
// leaves as one word. A short command queue sits between the parser and the
// emitter, so outside a frame body the parser keeps taking bytes while a
// result waits to be taken, until the queue is full.
module checksummed_frame_receiver
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic [0:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // body_byte, body_position, zero fill
	output logic [2:0]  m_tuser,   // frame_status
	output logic        m_tlast    // last_of_run
);

	cfr_cmd_t          push_cmd;
	cfr_cmd_t          head_cmd;
	cfr_wr_t           wr;
	logic              cmd_push;
	logic              cmd_pop;
	logic              cmd_full;
	logic              cmd_empty;
	logic              back_idle;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	cfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_full  (cmd_full),
		.cmd_empty (cmd_empty),
		.back_idle (back_idle),
		.cmd_push  (cmd_push),
		.cmd       (push_cmd),
		.wr        (wr)
	);

	cfr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.pop      (cmd_pop),
		.head     (head_cmd),
		.full     (cmd_full),
		.empty    (cmd_empty)
	);

	cfr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BODY)
	) u_store (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	cfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.idle      (back_idle),
		.raddr     (raddr),
		.rdata     (rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/core/cfr_ram.sv =====
//------------------------------------------------------------------------------
// cfr_ram
// Generic single write port, single read port RAM with registered read data.
//------------------------------------------------------------------------------
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/cfr_front.sv =====
//------------------------------------------------------------------------------
// cfr_front
// Frame parser: hunts for the start byte, checks the length, stores the body,
// keeps the running sum and issues one command per frame outcome.
//------------------------------------------------------------------------------
module cfr_front
	import cfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // rx_byte
	input  logic [0:0] s_tuser,   // action
	input  logic       cmd_full,
	input  logic       cmd_empty,
	input  logic       back_idle,
	output logic       cmd_push,
	output cfr_cmd_t   cmd,
	output cfr_wr_t    wr
);

	typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_BODY} phase_t;

	phase_t           phase_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] taken_q;
	logic [7:0]       sum_q;

	logic             accept;
	logic             timeout;
	logic [7:0]       new_sum;
	logic [LEN_W:0]   taken_next;
	logic             len_bad;

	assign timeout    = s_tuser[0];
	assign s_tready   = !cmd_full && (phase_q != PH_BODY || (cmd_empty && back_idle));
	assign accept     = s_tvalid && s_tready;
	assign new_sum    = sum_q + s_tdata;
	assign taken_next = {1'b0, taken_q} + 1'b1;
	assign len_bad    = (s_tdata < MIN_LEN) || (s_tdata > MAX_LEN);

	always_comb begin
		cmd_push   = 1'b0;
		cmd.status = ST_OK;
		cmd.length = len_q;
		wr.en      = 1'b0;
		wr.addr    = ADDR_W'(taken_q);
		wr.data    = s_tdata;
		if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					if (timeout || len_bad) begin
						cmd_push   = 1'b1;
						cmd.status = ST_BAD_LEN;
					end
				end
				PH_BODY: begin
					if (timeout) begin
						cmd_push   = 1'b1;
						cmd.status = ST_SHORT;
					end else begin
						wr.en = 1'b1;
						if (taken_next >= {1'b0, len_q}) begin
							cmd_push   = 1'b1;
							cmd.status = (new_sum != 8'h00) ? ST_CHECKSUM : ST_OK;
						end
					end
				end
				default: begin
					if (timeout) begin
						cmd_push   = 1'b1;
						cmd.status = ST_NO_START;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			taken_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					if (timeout || len_bad) begin
						phase_q <= PH_HUNT;
					end else begin
						len_q   <= s_tdata[LEN_W-1:0];
						taken_q <= '0;
						sum_q   <= s_tdata;
						phase_q <= PH_BODY;
					end
				end
				PH_BODY: begin
					if (timeout) begin
						phase_q <= PH_HUNT;
					end else begin
						taken_q <= taken_next[LEN_W-1:0];
						sum_q   <= new_sum;
						if (taken_next >= {1'b0, len_q}) begin
							phase_q <= PH_HUNT;
						end
					end
				end
				default: begin
					if (!timeout && s_tdata == START_BYTE) begin
						phase_q <= PH_LEN;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> back_idle && cmd_empty)
		else $error("body store written while a frame drains");

endmodule

// ===== rtl/core/cfr_fifo.sv =====
//------------------------------------------------------------------------------
// cfr_fifo
// Short command queue between the parser and the result emitter.
//------------------------------------------------------------------------------
module cfr_fifo
	import cfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cfr_cmd_t push_cmd,
	input  logic     pop,
	output cfr_cmd_t head,
	output logic     full,
	output logic     empty
);

	cfr_cmd_t           entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	logic do_pop;

	assign full   = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty  = (count_q == '0);
	assign head   = entry_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || do_pop)
		else $error("command queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("command queue count out of range");

endmodule

// ===== rtl/core/cfr_back.sv =====
//------------------------------------------------------------------------------
// cfr_back
// Result emitter: turns queued commands into result words, reading the body
// store for a good frame, behind an output register.
//------------------------------------------------------------------------------
module cfr_back
	import cfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfr_cmd_t          cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	output logic              idle,
	output logic [ADDR_W-1:0] raddr,
	input  logic [7:0]        rdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // body_byte, body_position, zero fill
	output logic [2:0]        m_tuser,   // frame_status
	output logic              m_tlast    // last_of_run
);

	typedef enum logic [1:0] {B_IDLE, B_READ, B_OUT} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_inc;

	assign idle    = (state_q == B_IDLE);
	assign cmd_pop = idle && cmd_valid;
	assign idx_inc = idx_q + 1'b1;
	assign raddr   = (state_q == B_OUT) ? ADDR_W'(idx_inc) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			idx_q    <= '0;
			len_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= ST_OK;
			m_tlast  <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						if (cmd.status != ST_OK) begin
							m_tvalid <= 1'b1;
							m_tdata  <= '0;
							m_tuser  <= cmd.status;
							m_tlast  <= 1'b1;
							state_q  <= B_OUT;
						end else begin
							len_q   <= cmd.length;
							idx_q   <= '0;
							state_q <= B_READ;
						end
					end
				end
				B_READ: begin
					m_tvalid <= 1'b1;
					m_tdata  <= {4'b0000, idx_q, rdata};
					m_tuser  <= ST_OK;
					m_tlast  <= (idx_inc == len_q);
					state_q  <= B_OUT;
				end
				B_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= B_READ;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == '0)
		else $error("error word must be a single zeroed last word");

	a_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK |-> m_tdata[11:8] < len_q)
		else $error("body position beyond frame length");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the checksummed frame receiver.
//------------------------------------------------------------------------------
// A short scripted line of bytes and timeouts is sent first. It covers a
// timeout while hunting, dropped bytes, every bad length case, a good frame,
// a body cut short and a checksum error. Random traffic follows: mostly
// well-formed frames of random length and content, mixed with corrupted
// checksums, cut bodies, bad lengths, stray timeouts and line noise. Every
// accepted word is run through a local deframer model. Every output word is
// compared with the oldest expected word. The sender works in bursts, and the
// receiver stalls on its own pattern, with one long hold-off that backs the
// block up.
//------------------------------------------------------------------------------
module tb;
	import cfr_pkg::*;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	localparam int RANDOM_WORDS   = 230;
	localparam int HOLD_AFTER     = 90;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_TAIL     = 64;
	localparam int N_SCRIPT       = 23;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
		logic       fixed;
		logic [2:0] fixed_status;
	} line_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] body_byte;
		logic [3:0] body_pos;
		logic       last;
	} resp_word_t;

	typedef enum logic [1:0] {HUNT, GET_LEN, GET_BODY} rx_phase_t;

	// Each row is action, byte, fixed expectation flag, fixed error status.
	localparam logic [12:0] LINE_SCRIPT [0:N_SCRIPT-1] = '{
		{ACT_TIMEOUT, 8'h00, 1'b1, ST_NO_START},
		{ACT_BYTE, 8'h00, 1'b0, ST_OK},
		{ACT_BYTE, 8'hFF, 1'b0, ST_OK},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_TIMEOUT, 8'hFF, 1'b1, ST_BAD_LEN},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_BYTE, 8'h01, 1'b1, ST_BAD_LEN},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_BYTE, 8'h0F, 1'b1, ST_BAD_LEN},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_BYTE, 8'h00, 1'b1, ST_BAD_LEN},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_BYTE, MIN_LEN, 1'b0, ST_OK},
		{ACT_BYTE, 8'hAB, 1'b0, ST_OK},
		{ACT_BYTE, 8'h53, 1'b0, ST_OK},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_BYTE, 8'h03, 1'b0, ST_OK},
		{ACT_BYTE, 8'h10, 1'b0, ST_OK},
		{ACT_TIMEOUT, 8'h00, 1'b1, ST_SHORT},
		{ACT_BYTE, START_BYTE, 1'b0, ST_OK},
		{ACT_BYTE, MIN_LEN, 1'b0, ST_OK},
		{ACT_BYTE, 8'h00, 1'b0, ST_OK},
		{ACT_BYTE, 8'h00, 1'b1, ST_CHECKSUM}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	logic       cur_fixed;
	logic [2:0] cur_fixed_status;

	line_word_t line_traffic [$];
	resp_word_t expected_words [$];
	resp_word_t step_words [$];

	rx_phase_t  mdl_phase = HUNT;
	logic [3:0] mdl_len   = '0;
	logic [3:0] mdl_taken = '0;
	logic [7:0] mdl_sum   = '0;
	logic [7:0] mdl_body [MAX_BODY];

	int unsigned failures     = 0;
	int unsigned words_in     = 0;
	int unsigned words_out    = 0;
	int unsigned good_frames  = 0;
	int unsigned idle_cycles  = 0;
	int unsigned err_count [5] = '{default: 0};
	logic [15:0] lengths_seen = '0;
	logic        held_off     = 1'b0;

	checksummed_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic add_word(input logic action, input logic [7:0] rx_byte);
		line_word_t w;
		w.action       = action;
		w.rx_byte      = rx_byte;
		w.fixed        = 1'b0;
		w.fixed_status = ST_OK;
		line_traffic.push_back(w);
	endtask

	// Deframer model: leaves the words caused by one line word in step_words.
	task automatic deframe_step(input logic action, input logic [7:0] rx_byte);
		resp_word_t w;
		step_words.delete();
		w = '0;
		w.last = 1'b1;
		case (mdl_phase)
		GET_LEN: begin
			mdl_phase = HUNT;
			if (action == ACT_TIMEOUT || rx_byte < MIN_LEN || rx_byte > MAX_LEN) begin
				w.status = ST_BAD_LEN;
				step_words.push_back(w);
			end else begin
				mdl_len   = rx_byte[3:0];
				mdl_taken = '0;
				mdl_sum   = rx_byte;
				mdl_phase = GET_BODY;
			end
		end
		GET_BODY: begin
			if (action == ACT_TIMEOUT) begin
				mdl_phase = HUNT;
				w.status  = ST_SHORT;
				step_words.push_back(w);
			end else begin
				mdl_body[mdl_taken] = rx_byte;
				mdl_taken = mdl_taken + 4'd1;
				mdl_sum   = mdl_sum + rx_byte;
				if (mdl_taken == mdl_len) begin
					mdl_phase = HUNT;
					if (mdl_sum != 8'h00) begin
						w.status = ST_CHECKSUM;
						step_words.push_back(w);
					end else begin
						for (int i = 0; i < int'(mdl_len); i++) begin
							w.status    = ST_OK;
							w.body_byte = mdl_body[i];
							w.body_pos  = i[3:0];
							w.last      = (i == int'(mdl_len) - 1);
							step_words.push_back(w);
						end
					end
				end
			end
		end
		default: begin
			mdl_phase = HUNT;
			if (action == ACT_TIMEOUT) begin
				w.status = ST_NO_START;
				step_words.push_back(w);
			end else if (rx_byte == START_BYTE) begin
				mdl_phase = GET_LEN;
			end
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : monitor
		resp_word_t w;
		resp_word_t exp_w;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				words_in++;
				deframe_step(s_tuser[0], s_tdata);
				if (cur_fixed) begin
					w = '0;
					w.status = cur_fixed_status;
					w.last   = 1'b1;
					expected_words.push_back(w);
				end else begin
					foreach (step_words[i])
						expected_words.push_back(step_words[i]);
				end
			end
			if (m_tvalid && m_tready) begin
				words_out++;
				if (expected_words.size() == 0) begin
					$error("output word with nothing expected: status %0d, byte 0x%02h",
						m_tuser, m_tdata[7:0]);
					failures++;
				end else begin
					exp_w = expected_words.pop_front();
					check_field("frame_status", 16'(exp_w.status), 16'(m_tuser));
					check_field("body_byte", 16'(exp_w.body_byte), 16'(m_tdata[7:0]));
					check_field("body_position", 16'(exp_w.body_pos), 16'(m_tdata[11:8]));
					check_field("zero_fill", 16'h0, 16'(m_tdata[15:12]));
					check_field("last_of_run", 16'(exp_w.last), 16'(m_tlast));
					if (exp_w.last && exp_w.status == ST_OK) begin
						good_frames++;
						lengths_seen[int'(exp_w.body_pos) + 1] = 1'b1;
					end else if (exp_w.status <= ST_CHECKSUM) begin
						err_count[exp_w.status]++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver: one long hold-off once traffic is well underway, otherwise a
	// pattern that rotates through full rate, light, periodic and heavy stalls.
	initial begin : receiver
		int unsigned rcv_cycle;
		rcv_cycle = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rcv_cycle++;
			if (!held_off && words_in >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case ((rcv_cycle / 96) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= (rcv_cycle % 5 != 0);
				default: m_tready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	initial begin : sender
		line_word_t w;
		int unsigned counted;
		int unsigned size_before;
		int unsigned kind;
		int unsigned len;
		int unsigned cut;
		int unsigned burst_left;
		int unsigned gap;
		logic [7:0]  sum;
		logic [7:0]  b;
		int unsigned n_lengths;

		arst_n           <= 1'b0;
		s_tvalid         <= 1'b0;
		s_tdata          <= '0;
		s_tuser          <= '0;
		cur_fixed        <= 1'b0;
		cur_fixed_status <= ST_OK;

		for (int i = 0; i < N_SCRIPT; i++)
			line_traffic.push_back(line_word_t'(LINE_SCRIPT[i]));

		counted = 0;
		while (counted < RANDOM_WORDS) begin
			size_before = line_traffic.size();
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				repeat ($urandom_range(1, 4))
					add_word(ACT_BYTE, 8'($urandom_range(0, 255)));
			end else if (kind < 14) begin
				add_word(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
			end else if (kind < 22) begin
				add_word(ACT_BYTE, START_BYTE);
				if ($urandom_range(0, 3) == 0)
					add_word(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
				else if ($urandom_range(0, 2) == 0)
					add_word(ACT_BYTE, 8'($urandom_range(0, 1)));
				else
					add_word(ACT_BYTE, 8'($urandom_range(MAX_BODY + 1, 255)));
			end else begin
				case ($urandom_range(0, 9))
				0, 1:    len = MAX_BODY;
				2:       len = 2;
				default: len = $urandom_range(2, MAX_BODY);
				endcase
				cut = (kind < 30) ? $urandom_range(0, len - 1) : len;
				add_word(ACT_BYTE, START_BYTE);
				add_word(ACT_BYTE, 8'(len));
				sum = 8'(len);
				for (int k = 0; k < int'(len) - 1 && k < int'(cut); k++) begin
					b = 8'($urandom_range(0, 255));
					sum = sum + b;
					add_word(ACT_BYTE, b);
				end
				if (cut < len) begin
					add_word(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
				end else begin
					b = 8'h00 - sum;
					if (kind < 38)
						b = b + 8'($urandom_range(1, 255));
					add_word(ACT_BYTE, b);
				end
			end
			if (kind >= 10)
				counted += line_traffic.size() - size_before;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = 0;
		foreach (line_traffic[i]) begin
			w = line_traffic[i];
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			s_tvalid         <= 1'b1;
			s_tdata          <= w.rx_byte;
			s_tuser          <= w.action;
			cur_fixed        <= w.fixed;
			cur_fixed_status <= w.fixed_status;
			do @(posedge clk); while (!s_tready);
			burst_left--;
		end
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		n_lengths = 0;
		for (int i = MIN_LEN; i <= MAX_BODY; i++)
			n_lengths += lengths_seen[i];
		$display("Sent %0d line words, checked %0d output words; %0d good frames, %0d of 13 lengths.",
			words_in, words_out, good_frames, n_lengths);
		$display("Errors: no start %0d, bad length %0d, short body %0d, checksum %0d.",
			err_count[ST_NO_START], err_count[ST_BAD_LEN], err_count[ST_SHORT],
			err_count[ST_CHECKSUM]);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
